FILE: hw/rtl/swm_pkg.sv
package swm_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int SAMPLE_W   = 32;
  localparam int MEDIAN_W   = SAMPLE_W + 1;
  localparam int CFG_W      = 5;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(3);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]           count_t;
  typedef logic [IDX_W-1:0]           index_t;

  // Map the written size onto 1..MAX_WINDOW: zero acts as one, large values saturate.
  function automatic count_t effective_size(input logic [CFG_W-1:0] ws);
    count_t k;
    if (int'(ws) == 0) begin
      k = CNT_W'(1);
    end else if (int'(ws) > MAX_WINDOW) begin
      k = CNT_W'(MAX_WINDOW);
    end else begin
      k = CNT_W'(ws);
    end
    return k;
  endfunction

endpackage

FILE: hw/rtl/sliding_window_median.sv
// Sliding-window median filter over signed 32-bit samples.
//
// Input channel (in_valid/in_ready): one word is a sample plus a first flag.
// A set first flag empties the window before the sample is taken. The window
// holds the last k samples, k taken from window_size (0 acts as 1, values
// above MAX_WINDOW saturate). The sample that fills the window, and every one
// after it, yields one output word: median_doubled, twice the median, i.e. the
// sum of the two middle sorted samples (the middle one doubled when k is odd).
//
// Config channel (cfg_valid/cfg_ready): writes window_size and empties the
// window. It is taken only while the block is idle and no sample is offered.
//
// Timing: the sorted list is updated at the accepting edge by a parallel rank
// compare across all window entries; the median is then summed into the
// output register, which raises out_valid, as soon as that register is free.
// A sample is taken every cycle while the output side keeps up.
// Reset clears the window and sets window_size to 3. When the receiver stalls,
// the output word holds and one more finished result may wait in the pending
// stage; after that in_ready drops until the output moves.
module sliding_window_median (
  input  logic                        clk,
  input  logic                        rst,
  input  logic signed [31:0]          sample,
  input  logic                        first,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic signed [32:0]          median_doubled,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  logic [swm_pkg::CFG_W-1:0]   window_size,
  input  logic                        cfg_valid,
  output logic                        cfg_ready
);
  import swm_pkg::*;

  // Window state: shift line in arrival order (newest at 0) and sorted row.
  sample_t    arrival [MAX_WINDOW];
  sample_t    sorted [MAX_WINDOW];
  sample_t    sorted_next [MAX_WINDOW];
  count_t     fill_count;
  count_t     fill_next;
  logic [CFG_W-1:0] size_reg;
  count_t     k_eff;
  logic       pend;            // sorted row holds a result not yet summed
  logic       in_take;
  logic       cfg_take;
  logic       out_load;
  logic       full_now;
  count_t     fill_base;
  count_t     rm_pos;          // sorted slot removed, MAX_WINDOW when none
  count_t     ins_pos;         // sorted slot the new sample lands in
  sample_t    oldest;
  index_t     lo_idx;
  index_t     hi_idx;

  assign k_eff    = effective_size(size_reg);
  assign out_load = pend && (!out_valid || out_ready);
  assign in_ready = !pend || out_load;
  assign cfg_ready = !pend && !out_valid && !in_valid;
  assign in_take  = in_valid && in_ready;
  assign cfg_take = cfg_valid && cfg_ready;

  assign lo_idx = IDX_W'((k_eff - CNT_W'(1)) >> 1);
  assign hi_idx = IDX_W'(k_eff >> 1);
  assign oldest = arrival[IDX_W'(k_eff - CNT_W'(1))];

  // Rank compare: find the evicted entry, then the insertion point.
  always_comb begin
    logic   found;
    count_t le_cnt;
    fill_base = (first || (fill_count > k_eff)) ? '0 : fill_count;
    full_now  = (fill_base == k_eff);
    rm_pos    = CNT_W'(MAX_WINDOW);
    found     = 1'b0;
    if (full_now) begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
        if (!found && (CNT_W'(j) < fill_base) && (sorted[j] == oldest)) begin
          rm_pos = CNT_W'(j);
          found  = 1'b1;
        end
      end
      if (!found) begin
        rm_pos = fill_base - CNT_W'(1);
      end
    end
    le_cnt = '0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      if ((CNT_W'(j) < fill_base) && (CNT_W'(j) != rm_pos) && (sorted[j] <= sample)) begin
        le_cnt = le_cnt + CNT_W'(1);
      end
    end
    ins_pos   = le_cnt;
    fill_next = full_now ? fill_base : fill_base + CNT_W'(1);
  end

  // Each sorted slot takes its own value, its upper or lower neighbor, or the new sample.
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (CNT_W'(i) < ins_pos) begin
        sorted_next[i] = (CNT_W'(i) < rm_pos) ? sorted[i] : sorted[IDX_W'(i + 1)];
      end else if (CNT_W'(i) == ins_pos) begin
        sorted_next[i] = sample;
      end else begin
        sorted_next[i] = (CNT_W'(i) <= rm_pos) ? sorted[IDX_W'(i - 1)] : sorted[i];
      end
    end
  end

  // Window payload: no reset, only entries below fill_count are ever used.
  always_ff @(posedge clk) begin
    if (in_take) begin
      arrival[0] <= sample;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        arrival[i] <= arrival[i-1];
      end
      sorted <= sorted_next;
    end
    if (out_load) begin
      median_doubled <= MEDIAN_W'(sorted[lo_idx]) + MEDIAN_W'(sorted[hi_idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      size_reg   <= WINDOW_RESET;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_take) begin
        // drop the window on every size write
        size_reg   <= window_size;
        fill_count <= '0;
      end else if (in_take) begin
        fill_count <= fill_next;
      end
      // a result follows every sample that leaves the window full
      if (in_take) begin
        pend <= (fill_next == k_eff);
      end else if (out_load) begin
        pend <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= k_eff)
    else $error("fill count exceeds window size");

  a_pend_full: assert property (@(posedge clk) disable iff (rst)
    pend |-> (fill_count == k_eff))
    else $error("pending result without a full window");

  a_first_restart: assert property (@(posedge clk) disable iff (rst)
    (in_take && first && (k_eff != CNT_W'(1))) |=> (fill_count == CNT_W'(1)) && !pend)
    else $error("first flag did not restart the window");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (fill_count >= CNT_W'(2)) |-> (sorted[0] <= sorted[1]))
    else $error("sorted row out of order");
`endif

endmodule

FILE: sim/sliding_window_median_checker.sv
module sliding_window_median_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  swm_pkg::sample_t                   sample,
  input  logic                               first,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [swm_pkg::MEDIAN_W-1:0] median_doubled,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [swm_pkg::CFG_W-1:0]          window_size,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  output int                                 mismatches,
  output int                                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import swm_pkg::*;

  // Window copy: ring in arrival order and ascending list.
  sample_t                    ring [MAX_WINDOW];
  sample_t                    ranked [MAX_WINDOW];
  int                         held;
  int                         oldest;
  logic [CFG_W-1:0]           size_setting;
  logic signed [MEDIAN_W-1:0] median_q [$];
  int                         mismatch_count = 0;

  assign mismatches = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: median mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int window_span();
    if (size_setting == '0) return 1;
    if (int'(size_setting) > MAX_WINDOW) return MAX_WINDOW;
    return int'(size_setting);
  endfunction

  // Advance the window by one sample; queue the doubled median once full.
  task automatic take_sample(input sample_t s, input logic restart);
    int k;
    int j;
    int p;
    sample_t gone;
    logic signed [MEDIAN_W-1:0] m;
    k = window_span();
    if (restart || held > k) begin
      held = 0;
      oldest = 0;
    end
    if (oldest >= k) oldest = 0;
    if (held == k) begin
      // drop one entry equal to the oldest sample
      gone = ring[oldest];
      j = 0;
      while (j < held && ranked[j] != gone) j++;
      if (j >= held) j = held - 1;
      while (j + 1 < held) begin
        ranked[j] = ranked[j + 1];
        j++;
      end
      held--;
      ring[oldest] = s;
      oldest = (oldest + 1 >= k) ? 0 : oldest + 1;
    end else begin
      ring[held] = s;
    end
    // insert after any equal entries
    p = 0;
    while (p < held && ranked[p] <= s) p++;
    for (j = held; j > p; j--) ranked[j] = ranked[j - 1];
    ranked[p] = s;
    held++;
    if (held == k) begin
      m = MEDIAN_W'(ranked[(k - 1) / 2]) + MEDIAN_W'(ranked[k / 2]);
      median_q = {median_q, m};
    end
  endtask

  always @(posedge clk) begin
    logic signed [MEDIAN_W-1:0] want;
    if (rst) begin
      held = 0;
      oldest = 0;
      size_setting = WINDOW_RESET;
      median_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (median_q.size() == 0) begin
          report_mismatch($sformatf("word %0d with none pending", median_doubled));
        end else begin
          want = median_q.pop_front();
          if (median_doubled !== want)
            report_mismatch($sformatf("median_doubled %0d, want %0d", median_doubled, want));
        end
      end
      if (cfg_valid && cfg_ready) begin
        size_setting = window_size;
        held = 0;
        oldest = 0;
      end
      if (in_valid && in_ready) take_sample(sample, first);
    end
    outstanding <= median_q.size();
  end

endmodule

FILE: sim/sliding_window_median_tb.sv
module sliding_window_median_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swm_pkg::*;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  sample_t                    sample = '0;
  logic                       first = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [MEDIAN_W-1:0] median_doubled;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [CFG_W-1:0]           window_size = '0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;

  int mismatches;
  int outstanding;

  // Gap-free stretch length left on the sample side.
  int      burst_left = 0;
  // Last sample sent; reused to create runs of equal values.
  sample_t last_sample = '0;

  sliding_window_median dut (
    .clk            (clk),
    .rst            (rst),
    .sample         (sample),
    .first          (first),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .median_doubled (median_doubled),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .window_size    (window_size),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready)
  );

  sliding_window_median_checker chk (
    .clk            (clk),
    .rst            (rst),
    .sample         (sample),
    .first          (first),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .median_doubled (median_doubled),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .window_size    (window_size),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hold reset from time zero, then release it for good.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Pick the idle gap before the next input word: mostly none or short,
  // a few long, and now and then a long gap-free burst.
  function int next_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Mix full-range values with the extremes, a narrow band around zero
  // and repeats of the previous value so that ties show up often.
  function sample_t next_sample();
    int unsigned r;
    sample_t v;
    r = $urandom_range(0, 19);
    if (r < 2) begin
      case ($urandom_range(0, 3))
        0:       v = sample_t'(32'h8000_0000);
        1:       v = sample_t'(32'h7FFF_FFFF);
        2:       v = sample_t'(-1);
        default: v = '0;
      endcase
    end else if (r < 7) begin
      v = sample_t'(int'($urandom_range(0, 8)) - 4);
    end else if (r < 10) begin
      v = last_sample;
    end else begin
      v = sample_t'($urandom);
    end
    last_sample = v;
    return v;
  endfunction

  // Offer one word after a random gap and hold it until it is taken.
  // Leave valid high afterwards so back-to-back words need no extra edge.
  task automatic send_word(input sample_t s, input logic f);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    first    <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every pending median, then let the pipeline settle
  // for a trailing word that produced no median.
  task automatic drain_window();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the window size while the block is idle.
  task automatic write_window(input logic [CFG_W-1:0] ws);
    cfg_valid   <= 1'b1;
    window_size <= ws;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, mostly short, some long, with long ready runs.
  initial begin
    int unsigned r;
    wait (!rst);
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(40, 150)) @(posedge clk);
      end else if (r < 55) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else if (r < 93) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(6, 30)) @(posedge clk);
      end
    end
  end

  // Directed words for the reset window of three: extremes that push the
  // doubled median to both ends of its range, restarts before and after the
  // window fills, and runs of equal values across eviction.
  localparam int DIRECTED_N = 22;
  localparam sample_t DIR_SAMPLE [DIRECTED_N] = '{
    32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
    32'sh8000_0000, 32'sh8000_0000, -32'sd1,        32'sd0,
    32'sd0,         32'sd7,         32'sd7,         -32'sd7,
    -32'sd7,        -32'sd7,        32'sd5,         32'sd5,
    -32'sd3,        32'sd5,         -32'sd3,        32'sd5,
    32'sh8000_0000, 32'sh7FFF_FFFF
  };
  localparam logic DIR_FIRST [DIRECTED_N] = '{
    1'b1, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b1, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0
  };

  // Window sizes per random phase: one, full, zero (acts as one), the top
  // of the field and just above the maximum (both saturate), then even and
  // odd sizes in between. A random size closes the list.
  localparam int PHASES = 11;
  localparam logic [CFG_W-1:0] PHASE_SIZE [PHASES] = '{
    5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd5, 5'd8, 5'd4, 5'd11, 5'd3
  };
  localparam int WORDS_PER_PHASE = 115;

  initial begin
    int n;
    wait (!rst);
    @(posedge clk);

    for (int i = 0; i < DIRECTED_N; i++) send_word(DIR_SAMPLE[i], DIR_FIRST[i]);
    drain_window();

    for (int ph = 0; ph <= PHASES; ph++) begin
      if (ph < PHASES) write_window(PHASE_SIZE[ph]);
      else write_window(CFG_W'($urandom_range(0, 31)));
      // Keep restarts rare so the window mostly fills and slides.
      for (int i = 0; i < WORDS_PER_PHASE; i++)
        send_word(next_sample(), $urandom_range(0, 99) < 3);
      drain_window();
    end

    // Give a missing median a bounded chance to arrive, then keep the clock
    // running so a stray extra word would still be caught.
    n = 0;
    while (outstanding != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("sliding_window_median_tb: clean");
    end else begin
      $display("sliding_window_median_tb: errors");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2_000_000;
    $display("sliding_window_median_tb: errors");
    $finish;
  end

endmodule
